@@ rtl/core/wma_pkg.sv @@
package wma_pkg;

  // largest window the ring can hold
  localparam int unsigned MaxWindow = 32;

  localparam int unsigned ReadingW = 16;
  localparam int unsigned WinW     = 6;
  localparam int unsigned SlotW    = $clog2(MaxWindow);
  localparam int unsigned CntW     = WinW;
  // sum of MaxWindow readings of ReadingW bits
  localparam int unsigned SumW     = ReadingW + $clog2(MaxWindow);

  // one quotient bit per divider step
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StFin
  } wma_state_e;

  typedef struct packed {
    logic start;
    logic div_step;
    logic out_load;
  } wma_cmd_t;

  typedef struct packed {
    logic div_last;
  } wma_status_t;

endpackage

@@ rtl/core/wma_ctrl.sv @@
module wma_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  wma_pkg::wma_status_t status_i,
  output wma_pkg::wma_cmd_t    cmd_o
);
  import wma_pkg::*;

  wma_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        // wait for the output register to drain
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/wma_dp.sv @@
module wma_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wma_pkg::wma_cmd_t             cmd_i,
  output wma_pkg::wma_status_t          status_o,
  input  logic                          cfg_we_i,
  input  logic [wma_pkg::WinW-1:0]      cfg_window_i,
  input  logic [wma_pkg::ReadingW-1:0]  reading_i,
  output logic [wma_pkg::ReadingW-1:0]  average_o
);
  import wma_pkg::*;

  logic [ReadingW-1:0] ring_q [MaxWindow];
  logic [MaxWindow-1:0] valid_q, valid_d;
  logic [WinW-1:0]     window_q, window_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [CntW-1:0]     seen_q, seen_d;
  logic [DivCntW-1:0]  div_cnt_q, div_cnt_d;

  logic [SumW-1:0]     div_sh_q, div_sh_d;
  logic [WinW-1:0]     rem_q, rem_d;
  logic [WinW-1:0]     divisor_q, divisor_d;
  logic [ReadingW-1:0] avg_q;

  logic [ReadingW-1:0] old_val;
  logic [SumW-1:0]     sum_upd;
  logic [WinW-1:0]     slot_inc;
  logic [SlotW-1:0]    slot_nxt;
  logic [CntW-1:0]     seen_upd;
  logic [WinW-1:0]     div_sel;
  logic [WinW-1:0]     win_clamp;
  logic [WinW:0]       trial;
  logic [WinW:0]       trial_sub;
  logic                trial_ge;

  // slot not written since the last clear reads as zero
  assign old_val  = valid_q[slot_q] ? ring_q[slot_q] : '0;
  assign sum_upd  = sum_q - SumW'(old_val) + SumW'(reading_i);
  assign slot_inc = WinW'(slot_q) + WinW'(1);
  assign slot_nxt = (slot_inc >= window_q) ? '0 : slot_inc[SlotW-1:0];
  assign seen_upd = (seen_q <= CntW'(window_q)) ? seen_q + CntW'(1) : seen_q;
  assign div_sel  = (seen_upd <= CntW'(window_q)) ? WinW'(seen_upd) : window_q;

  always_comb begin
    if (cfg_window_i == '0) begin
      win_clamp = WinW'(1);
    end else if (cfg_window_i > WinW'(MaxWindow)) begin
      win_clamp = WinW'(MaxWindow);
    end else begin
      win_clamp = cfg_window_i;
    end
  end

  // restoring divider, one quotient bit per step
  assign trial     = {rem_q, div_sh_q[SumW-1]};
  assign trial_ge  = trial >= {1'b0, divisor_q};
  assign trial_sub = trial - {1'b0, divisor_q};

  always_comb begin
    window_d  = window_q;
    sum_d     = sum_q;
    slot_d    = slot_q;
    seen_d    = seen_q;
    valid_d   = valid_q;
    div_cnt_d = div_cnt_q;
    div_sh_d  = div_sh_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (cfg_we_i) begin
      window_d = win_clamp;
      sum_d    = '0;
      slot_d   = '0;
      seen_d   = '0;
      valid_d  = '0;
    end else if (cmd_i.start) begin
      sum_d           = sum_upd;
      slot_d          = slot_nxt;
      seen_d          = seen_upd;
      valid_d[slot_q] = 1'b1;
      div_cnt_d       = '0;
      div_sh_d        = sum_upd;
      rem_d           = '0;
      divisor_d       = div_sel;
    end else if (cmd_i.div_step) begin
      div_cnt_d = div_cnt_q + DivCntW'(1);
      div_sh_d  = {div_sh_q[SumW-2:0], trial_ge};
      rem_d     = trial_ge ? trial_sub[WinW-1:0] : trial[WinW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WinW'(1);
      sum_q     <= '0;
      slot_q    <= '0;
      seen_q    <= '0;
      valid_q   <= '0;
      div_cnt_q <= '0;
    end else begin
      window_q  <= window_d;
      sum_q     <= sum_d;
      slot_q    <= slot_d;
      seen_q    <= seen_d;
      valid_q   <= valid_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start && !cfg_we_i) begin
      ring_q[slot_q] <= reading_i;
    end
    if (cmd_i.out_load) begin
      avg_q <= div_sh_q[ReadingW-1:0];
    end
    div_sh_q  <= div_sh_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign status_o.div_last = (div_cnt_q == DivCntW'(DivSteps - 1));
  assign average_o         = avg_q;

endmodule

@@ rtl/core/windowed_moving_average_core.sv @@
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+---------------------
// input    | in        | in_valid_i/in_ready_o  | reading_i [15:0]
// output   | out       | out_valid_o/out_ready_i| average_o [15:0]
// config   | in        | cfg_valid_i/cfg_ready_o| window_size_i [5:0]
//
// the reading transfer itself updates the ring and running sum, then the
// radix-2 divider works out one quotient bit per step for each bit of the
// 21-bit sum, then the output register is loaded once it is free; only
// then is the next reading taken, not while a division is under way
// the output register frees the input side: a new reading is taken while a
// result still waits downstream; a second finished result waits for it
// reset (async, active low) and any window write clear the ring, sum, slot
// and seen count; reset sets the window to 1
module windowed_moving_average_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wma_pkg::ReadingW-1:0]  reading_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wma_pkg::ReadingW-1:0]  average_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wma_pkg::WinW-1:0]      window_size_i
);
  import wma_pkg::*;

  wma_cmd_t    cmd;
  wma_status_t status;

  // window writes must only arrive while the block is idle; this block does not check that and always takes them
  assign cfg_ready_o = 1'b1;

  // sequencer: accept, divide, hand off result
  wma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // ring, running sum, counters and serial divider
  wma_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_valid_i),
    .cfg_window_i (window_size_i),
    .reading_i    (reading_i),
    .average_o    (average_o)
  );

endmodule

@@ sim/tb_windowed_moving_average_core.sv @@
module tb_windowed_moving_average_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wma_pkg::*;

  localparam int unsigned HalfPeriod = 4;
  localparam int unsigned IdlePct    = 23;
  localparam int unsigned ItemTarget = 1600;
  localparam int unsigned CycleLimit = 600000;
  // idle tail after the last phase, before the final check
  localparam int unsigned TailCycles = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // stimulus side
  logic                in_valid   = 1'b0;
  logic [ReadingW-1:0] in_reading = '0;
  logic                out_ready  = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic [WinW-1:0]     cfg_window = '0;

  logic                in_ready;
  logic                out_valid;
  logic [ReadingW-1:0] out_average;
  logic                cfg_ready;

  // readings waiting for the driver, averages waiting for the monitor
  logic [ReadingW-1:0] reading_q[$];
  logic [ReadingW-1:0] avg_due[$];

  // no random idling on either side while set
  logic    calm = 1'b0;
  int      errors = 0;
  int      items_sent = 0;
  int      cycles = 0;

  // predictor state: ring, running sum, slot, seen count, window
  logic [ReadingW-1:0] ring[MaxWindow];
  logic [SumW-1:0]     sum_acc;
  logic [SlotW-1:0]    slot;
  logic [CntW-1:0]     seen;
  logic [WinW-1:0]     win;

  logic in_fire;

  windowed_moving_average_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .reading_i     (in_reading),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .average_o     (out_average),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .window_size_i (cfg_window)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // ring, sum, slot and seen count all go back to zero on reset and window writes
  function automatic void clear_window();
    foreach (ring[i]) ring[i] = '0;
    sum_acc = '0;
    slot    = '0;
    seen    = '0;
  endfunction

  // zero stores one, anything past the largest window stores the largest
  function automatic void load_window(input logic [WinW-1:0] v);
    if (v == '0) begin
      win = WinW'(1);
    end else if (int'(v) > int'(MaxWindow)) begin
      win = WinW'(MaxWindow);
    end else begin
      win = v;
    end
    clear_window();
  endfunction

  // push one reading into the ring and return the truncated mean
  function automatic logic [ReadingW-1:0] slide_window(input logic [ReadingW-1:0] r);
    int              nxt;
    logic [SumW-1:0] divisor;
    sum_acc    = sum_acc - SumW'(ring[slot]) + SumW'(r);
    ring[slot] = r;
    nxt = int'(slot) + 1;
    slot = (nxt >= int'(win)) ? '0 : SlotW'(nxt);
    if (seen <= CntW'(win)) begin
      seen = seen + 1'b1;
    end
    // warm-up divides by the readings seen so far
    divisor = (seen <= CntW'(win)) ? SumW'(seen) : SumW'(win);
    return ReadingW'(sum_acc / divisor);
  endfunction

  // reading driver: predicts at each transfer, then offers the next reading
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      in_fire = in_valid && in_ready;
      if (in_fire) begin
        avg_due.push_back(slide_window(in_reading));
      end
      if (!in_valid || in_fire) begin
        if (reading_q.size() > 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          in_valid   <= 1'b1;
          in_reading <= reading_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // average monitor with random backpressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (avg_due.size() == 0) begin
          errors++;
          $display("%0t: average with nothing due, expected none actual %0d",
                   $time, out_average);
        end else if (out_average !== avg_due[0]) begin
          errors++;
          $display("%0t: average mismatch, expected %0d actual %0d",
                   $time, avg_due[0], out_average);
          void'(avg_due.pop_front());
        end else begin
          void'(avg_due.pop_front());
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // queue one reading, called away from the rising edge
  task automatic feed(input logic [ReadingW-1:0] r);
    reading_q.push_back(r);
    items_sent++;
  endtask

  // wait at falling edges, once the driver has settled, until every reading
  // went in and every average came out
  task automatic drain();
    do @(negedge clk_i);
    while (reading_q.size() != 0 || in_valid || avg_due.size() != 0);
  endtask

  // window write while the block is idle; ends on a rising edge
  task automatic set_window(input logic [WinW-1:0] v);
    cfg_window <= v;
    cfg_valid  <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    load_window(v);
  endtask

  // mostly full-range readings, with a bias toward the ends of the range
  function automatic logic [ReadingW-1:0] pick_reading();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return ReadingW'($urandom_range(15));
      3: return '1 - ReadingW'($urandom_range(15));
      default: return ReadingW'($urandom);
    endcase
  endfunction

  function automatic logic [WinW-1:0] pick_window();
    case ($urandom_range(7))
      0: return '0;
      1: return WinW'(1);
      2: return WinW'(MaxWindow);
      3: return '1;
      4: return WinW'($urandom_range(MaxWindow + 1, 63));
      default: return WinW'($urandom_range(2, MaxWindow - 1));
    endcase
  endfunction

  initial begin
    int phase;
    int len;
    load_window(WinW'(1));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // window of one after reset: average follows the reading
    @(negedge clk_i);
    feed('0);
    feed('1);
    feed(16'h0001);
    drain();

    // zero written, stored as one
    set_window('0);
    @(negedge clk_i);
    feed(16'h8000);
    feed(16'h7fff);
    drain();

    // small window, full-scale readings through warm-up and wrap
    set_window(WinW'(4));
    @(negedge clk_i);
    repeat (6) feed('1);
    feed('0);
    feed('0);
    drain();

    // above the largest window, clamped; warm-up divides by 1, 2, 3
    set_window(WinW'(33));
    @(negedge clk_i);
    feed('1);
    feed(16'h0001);
    feed(16'h0002);
    drain();

    // window of two, alternating extremes
    set_window(WinW'(2));
    @(negedge clk_i);
    for (int i = 0; i < 8; i++) begin
      feed((i % 2 == 0) ? '1 : '0);
    end
    drain();

    phase = 0;
    while (items_sent < ItemTarget) begin
      if (phase == 4) begin
        // long stretch without idling on a full window, opening with full-scale readings
        set_window('1);
        @(negedge clk_i);
        calm = 1'b1;
        len = 250;
      end else begin
        set_window(pick_window());
        @(negedge clk_i);
        calm = 1'b0;
        len = $urandom_range(10, 100);
      end
      for (int i = 0; i < len; i++) begin
        feed((phase == 4 && i < 40) ? '1 : pick_reading());
      end
      drain();
      phase++;
    end
    calm = 1'b0;

    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (errors == 0 && avg_due.size() == 0 && reading_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/wma_pkg.sv
rtl/core/wma_ctrl.sv
rtl/core/wma_dp.sv
rtl/core/windowed_moving_average_core.sv
sim/tb_windowed_moving_average_core.sv
